### hw/rtl/npct_pkg.sv
// Package: constants, widths and the seed prime table for the nth-prime block.
`default_nettype none
package npct_pkg;
  localparam int TABLE_DEPTH = 4096;
  localparam int VALUE_WIDTH = 20;
  localparam int INDEX_WIDTH = 20;
  localparam int OUT_WIDTH   = 20;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  // highest entry held by the seed table after reset
  localparam logic [ADDR_W-1:0] SEED_TOP = ADDR_W'(4);

  localparam logic [VALUE_WIDTH-1:0] STEP_SHORT = VALUE_WIDTH'(2);
  localparam logic [VALUE_WIDTH-1:0] STEP_LONG  = VALUE_WIDTH'(4);

  // seed entries 0..4: 1,2,3,5,7
  function automatic logic [VALUE_WIDTH-1:0] seed_prime(input logic [2:0] sel);
    logic [VALUE_WIDTH-1:0] v;
    case (sel)
      3'd0:    v = VALUE_WIDTH'(1);
      3'd1:    v = VALUE_WIDTH'(2);
      3'd2:    v = VALUE_WIDTH'(3);
      3'd3:    v = VALUE_WIDTH'(5);
      3'd4:    v = VALUE_WIDTH'(7);
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/npct_div.sv
// Restoring divider, one quotient bit per cycle, gives quotient and remainder.
`default_nettype none
module npct_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [npct_pkg::VALUE_WIDTH-1:0] dividend,
  input  wire logic [npct_pkg::VALUE_WIDTH-1:0] divisor,
  output logic                                  done,
  output logic      [npct_pkg::VALUE_WIDTH-1:0] quotient,
  output logic      [npct_pkg::VALUE_WIDTH-1:0] remainder
);
  import npct_pkg::*;

  logic [VALUE_WIDTH-1:0] dvsr;
  logic [CNT_W-1:0]       cnt;
  logic                   running;
  logic [VALUE_WIDTH:0]   trial;
  logic                   fits;

  // shift next dividend bit into the partial remainder
  assign trial = {remainder, quotient[VALUE_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running   <= 1'b1;
      done      <= 1'b0;
      cnt       <= CNT_W'(VALUE_WIDTH);
      dvsr      <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (running) begin
      remainder <= fits ? VALUE_WIDTH'(trial - {1'b0, dvsr}) : trial[VALUE_WIDTH-1:0];
      quotient  <= {quotient[VALUE_WIDTH-2:0], fits};
      cnt       <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/nth_prime_cached_table.sv
// Top level: nth-prime lookup with a prime table that grows on demand.
//
// Input channel (in_valid/in_ready, field index) takes one transaction at a
// time; in_ready is high only while the sequencer is idle. Output channel
// (out_valid/out_ready, fields prime_value and out_of_range) is a holding
// register, so a finished result waits there while the next index is taken.
//
// Path from acceptance to out_valid:
//   index at or beyond the table depth : result 0 with out_of_range.
//   index already in the table         : one registered RAM read.
//   index past the filled part         : the table is extended prime by
//     prime. Every candidate on the 6k+-1 wheel is trial-divided by stored
//     primes p while p*p <= candidate; each divisor takes a RAM read,
//     a divider load, a pass through the one shared bit-serial divider
//     and a verdict; the quotient gives the p*p bound, the remainder
//     the divisibility test.
// One transaction is taken at a time: the next index is taken in the
// cycle out_valid rises.
//
// Reset (rst, synchronous) returns the table to the seed primes 1,2,3,5,7,
// held as constants, and the wheel phase to 0. The RAM is not cleared: no
// entry above the filled top is ever used. If out_ready stays low, a
// completed result parks in the sequencer until the output register drains.
`default_nettype none
module nth_prime_cached_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [npct_pkg::INDEX_WIDTH-1:0] index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [npct_pkg::OUT_WIDTH-1:0]   prime_value,
  output logic                                  out_of_range
);
  import npct_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_EXT   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_DIVLD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_CHK   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]             state;
  logic [ADDR_W-1:0]      filled_top;
  logic [ADDR_W-1:0]      target;
  logic [ADDR_W:0]        k;            // divisor entry, may pass filled_top
  logic                   phase;
  logic                   saved_phase;
  logic [VALUE_WIDTH-1:0] last_prime;   // mirror of the table entry at filled_top (seed or prime_store)
  logic [VALUE_WIDTH-1:0] cand;
  logic [VALUE_WIDTH-1:0] p_reg;
  logic [VALUE_WIDTH-1:0] res_val;
  logic                   res_oor;

  // table RAM, entries above the seed only
  logic [VALUE_WIDTH-1:0] prime_store [TABLE_DEPTH];
  logic [ADDR_W-1:0]      rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   seed_hit_q;
  logic [VALUE_WIDTH-1:0] seed_val_q;
  logic [VALUE_WIDTH-1:0] p_mux;
  logic                   mem_we;
  logic [ADDR_W-1:0]      ft_inc;

  // wheel arithmetic
  logic [VALUE_WIDTH-1:0] first_step;
  logic [VALUE_WIDTH:0]   first_sum;
  logic [VALUE_WIDTH-1:0] next_step;
  logic [VALUE_WIDTH:0]   next_sum;

  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;

  logic                   k_past_top;
  logic                   found;
  logic                   composite;

  assign in_ready = (state == S_IDLE);

  assign rd_addr = (state == S_IDLE) ? index[ADDR_W-1:0] : k[ADDR_W-1:0];
  assign p_mux   = seed_hit_q ? seed_val_q : rd_data;
  assign ft_inc  = filled_top + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prime_store[ft_inc] <= cand;
    end
    rd_data    <= prime_store[rd_addr];
    seed_hit_q <= (rd_addr <= SEED_TOP);
    seed_val_q <= seed_prime(rd_addr[2:0]);
  end

  // step after the last stored prime, and after a rejected candidate
  assign first_step = phase ? STEP_SHORT : STEP_LONG;
  assign first_sum  = {1'b0, last_prime} + {1'b0, first_step};
  assign next_step  = phase ? STEP_LONG : STEP_SHORT;   // phase flips first
  assign next_sum   = {1'b0, cand} + {1'b0, next_step};

  assign k_past_top = (k > {1'b0, filled_top});
  assign found      = ((state == S_RD) && k_past_top) ||
                      ((state == S_CHK) && (p_reg > div_quo));
  assign composite  = (state == S_CHK) && !(p_reg > div_quo) && (div_rem == '0);
  assign mem_we     = found;
  assign div_start  = (state == S_DIVLD);

  npct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cand),
    .divisor  (p_mux),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      filled_top <= SEED_TOP;
      phase      <= 1'b0;
      last_prime <= seed_prime(3'd4);
      out_valid  <= 1'b0;
    end else begin
      // drain; a reload in S_OUT takes the slot instead
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (index >= INDEX_WIDTH'(TABLE_DEPTH)) begin
              res_val <= '0;
              res_oor <= 1'b1;
              state   <= S_OUT;
            end else begin
              target <= index[ADDR_W-1:0];
              state  <= (index[ADDR_W-1:0] <= filled_top) ? S_LOOK : S_EXT;
            end
          end
        end
        S_LOOK: begin
          res_val <= p_mux;
          res_oor <= 1'b0;
          state   <= S_OUT;
        end
        S_EXT: begin
          saved_phase <= phase;
          if (first_sum[VALUE_WIDTH]) begin
            res_val <= '0;
            res_oor <= 1'b1;
            state   <= S_OUT;
          end else begin
            cand  <= first_sum[VALUE_WIDTH-1:0];
            k     <= (ADDR_W+1)'(1);
            state <= S_RD;
          end
        end
        S_RD: begin
          if (!found) begin
            state <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          p_reg <= p_mux;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!found && !composite) begin
            k     <= k + (ADDR_W+1)'(1);
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            prime_value  <= OUT_WIDTH'(res_val);
            out_of_range <= res_oor;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // candidate verdicts
      if (found) begin
        phase      <= ~phase;
        filled_top <= ft_inc;
        last_prime <= cand;
        if (ft_inc < target) begin
          state <= S_EXT;
        end else begin
          res_val <= cand;
          res_oor <= 1'b0;
          state   <= S_OUT;
        end
      end else if (composite) begin
        if (next_sum[VALUE_WIDTH]) begin
          phase   <= saved_phase;
          res_val <= '0;
          res_oor <= 1'b1;
          state   <= S_OUT;
        end else begin
          phase <= ~phase;
          cand  <= next_sum[VALUE_WIDTH-1:0];
          k     <= (ADDR_W+1)'(1);
          state <= S_RD;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/npct_chk.sv
// Port-level checker for the nth-prime block, bound to the top level.
`default_nettype none
module npct_chk (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [npct_pkg::INDEX_WIDTH-1:0] index,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [npct_pkg::OUT_WIDTH-1:0]   prime_value,
  input wire logic                             out_of_range
);
  import npct_pkg::*;

  // one transaction in flight: ready drops right after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(prime_value) && $stable(out_of_range)))
    else $error("result changed while stalled");

  // flagged results carry zero, good ones never do
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_of_range == (prime_value == '0)))
    else $error("prime_value and out_of_range disagree");

  // with the output empty, an index beyond the table gives a flagged result once S_OUT loads the output register
  a_range: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (index >= INDEX_WIDTH'(TABLE_DEPTH)) && !out_valid)
      |=> ##1 (out_valid && out_of_range))
    else $error("out-of-range index not flagged");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid set straight after reset");
endmodule

bind nth_prime_cached_table npct_chk u_npct_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .index        (index),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .prime_value  (prime_value),
  .out_of_range (out_of_range)
);
`default_nettype wire
